### rtl/core/efd_pkg.sv
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants for the escaped frame deframer.
// ----------------------------------------------------------------------------
package efd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned INDEX_W = 2;

    // Decoded bytes in the header: destination and length
    localparam logic [COUNT_W-1:0] HEADER_BYTES = 9'd2;

    localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'd224;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd208;
    localparam logic [BYTE_W-1:0] MAXLEN_RESET = 8'd255;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_SYNC   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_ESCAPE = 2'd1;
    localparam logic [INDEX_W-1:0] REG_MAXLEN = 2'd2;

    // Result event codes
    localparam logic EVT_BYTE  = 1'b0;
    localparam logic EVT_ABORT = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [BYTE_W-1:0] escape_value;
        logic [BYTE_W-1:0] max_length;
    } efd_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              event_res;
        logic              frame_start;
        logic              frame_end;
        logic              last_of_run;
    } efd_result_t;

    // Results produced by one input item
    typedef struct packed {
        logic [1:0]  count;
        efd_result_t first;
        efd_result_t second;
    } efd_bundle_t;

endpackage

### rtl/core/efd_if.sv
// ----------------------------------------------------------------------------
// efd channel interfaces
// Valid/ready channels for received bytes, results and configuration writes.
// ----------------------------------------------------------------------------
interface efd_byte_if;
    logic                        valid;
    logic                        ready;
    logic [efd_pkg::BYTE_W-1:0]  byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface efd_result_if;
    logic                        valid;
    logic                        ready;
    logic [efd_pkg::BYTE_W-1:0]  byte_out;
    logic                        event_res;
    logic                        frame_start;
    logic                        frame_end;
    logic                        last_of_run;

    modport source (output valid, output byte_out, output event_res, output frame_start,
                    output frame_end, output last_of_run, input ready);
    modport sink   (input valid, input byte_out, input event_res, input frame_start,
                    input frame_end, input last_of_run, output ready);
endinterface

interface efd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [efd_pkg::INDEX_W-1:0]  index;
    logic [efd_pkg::BYTE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/efd_decode.sv
// ----------------------------------------------------------------------------
// efd_decode
// Frame tracking state and per-byte decode into up to two results.
// ----------------------------------------------------------------------------
module efd_decode
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  logic [efd_pkg::BYTE_W-1:0] byte_in,
    input  efd_pkg::efd_cfg_t          cfg,
    output efd_pkg::efd_bundle_t       bundle
);

    logic                        in_frame_reg, in_frame_next;
    logic                        esc_pend_reg, esc_pend_next;
    logic [efd_pkg::COUNT_W-1:0] decoded_reg, decoded_next;
    logic [efd_pkg::COUNT_W-1:0] needed_reg, needed_next;

    logic [efd_pkg::BYTE_W-1:0]  value;
    logic [efd_pkg::COUNT_W-1:0] cnt_inc;
    logic [efd_pkg::COUNT_W-1:0] need_eff;
    efd_pkg::efd_result_t        abort_res;
    efd_pkg::efd_result_t        byte_res;

    always_comb
    begin
        value    = esc_pend_reg ? byte_in + 8'd1 : byte_in;
        cnt_inc  = decoded_reg + 9'd1;
        need_eff = (cnt_inc == efd_pkg::HEADER_BYTES)
                 ? efd_pkg::HEADER_BYTES + {1'b0, value} : needed_reg;

        abort_res             = '0;
        abort_res.event_res   = efd_pkg::EVT_ABORT;
        byte_res              = '0;
        byte_res.byte_out     = byte_in;
        byte_res.event_res    = efd_pkg::EVT_BYTE;
        byte_res.last_of_run  = 1'b1;

        in_frame_next = in_frame_reg;
        esc_pend_next = esc_pend_reg;
        decoded_next  = decoded_reg;
        needed_next   = needed_reg;
        bundle        = '0;

        priority if (byte_in == cfg.sync_value)
        begin
            // abort any partial frame, open a new one
            byte_res.frame_start = 1'b1;
            if (in_frame_reg)
            begin
                bundle.count  = 2'd2;
                bundle.first  = abort_res;
                bundle.second = byte_res;
            end
            else
            begin
                bundle.count = 2'd1;
                bundle.first = byte_res;
            end
            in_frame_next = 1'b1;
            esc_pend_next = 1'b0;
            decoded_next  = '0;
            needed_next   = efd_pkg::HEADER_BYTES;
        end
        else if (!in_frame_reg)
        begin
            // hunting: drop
        end
        else if (!esc_pend_reg && byte_in == cfg.escape_value)
        begin
            esc_pend_next = 1'b1;
            bundle.count  = 2'd1;
            bundle.first  = byte_res;
        end
        else if (cnt_inc == efd_pkg::HEADER_BYTES && value > cfg.max_length)
        begin
            abort_res.last_of_run = 1'b1;
            bundle.count  = 2'd1;
            bundle.first  = abort_res;
            in_frame_next = 1'b0;
            esc_pend_next = 1'b0;
            decoded_next  = '0;
            needed_next   = efd_pkg::HEADER_BYTES;
        end
        else if (cnt_inc >= need_eff)
        begin
            byte_res.frame_end = 1'b1;
            bundle.count  = 2'd1;
            bundle.first  = byte_res;
            in_frame_next = 1'b0;
            esc_pend_next = 1'b0;
            decoded_next  = '0;
            needed_next   = efd_pkg::HEADER_BYTES;
        end
        else
        begin
            bundle.count  = 2'd1;
            bundle.first  = byte_res;
            esc_pend_next = 1'b0;
            decoded_next  = cnt_inc;
            needed_next   = need_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_pend_reg <= 1'b0;
            decoded_reg  <= '0;
            needed_reg   <= efd_pkg::HEADER_BYTES;
        end
        else if (fire)
        begin
            in_frame_reg <= in_frame_next;
            esc_pend_reg <= esc_pend_next;
            decoded_reg  <= decoded_next;
            needed_reg   <= needed_next;
        end
    end

endmodule

### rtl/core/efd_outq.sv
// ----------------------------------------------------------------------------
// efd_outq
// Two-entry result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module efd_outq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  efd_pkg::efd_bundle_t bundle,
    output logic                 room,
    efd_result_if.source         tx
);

    efd_pkg::efd_result_t slot_reg [2];
    logic [1:0]           count_reg, count_next;
    logic                 rd_reg, rd_next;
    logic                 pop;
    logic                 wr0, wr1;
    logic [1:0]           n_push;

    assign pop    = tx.valid && tx.ready;
    // room for two whole results after this cycle's pop
    assign room   = (count_reg == 2'd0) || (count_reg == 2'd1 && pop);
    assign n_push = push ? bundle.count : 2'd0;
    assign wr0    = rd_reg ^ count_reg[0];
    assign wr1    = ~wr0;

    always_comb
    begin
        rd_next    = rd_reg ^ pop;
        count_next = count_reg - {1'b0, pop} + n_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            slot_reg[wr0] <= bundle.first;
        end
        if (n_push == 2'd2)
        begin
            slot_reg[wr1] <= bundle.second;
        end
    end

    assign tx.valid       = (count_reg != 2'd0);
    assign tx.byte_out    = slot_reg[rd_reg].byte_out;
    assign tx.event_res   = slot_reg[rd_reg].event_res;
    assign tx.frame_start = slot_reg[rd_reg].frame_start;
    assign tx.frame_end   = slot_reg[rd_reg].frame_end;
    assign tx.last_of_run = slot_reg[rd_reg].last_of_run;

endmodule

### rtl/core/escaped_frame_deframer.sv
// ----------------------------------------------------------------------------
// escaped_frame_deframer
// Finds escaped serial frames and passes their raw bytes on with marks.
// ----------------------------------------------------------------------------
// Usage:
//   rx  takes one received serial byte per item (valid/ready).
//   tx  gives result items: a raw frame byte or an abort event, with
//       frame_start, frame_end and last_of_run marks.
//   cfg writes sync_value (0), escape_value (1) and max_length (2); other
//       indexes are ignored. Always ready; write only while idle.
// An accepted byte waits in the input register; its decoded results go into
//   the result queue, which drives tx. One byte per cycle while each byte
//   gives at most one result and tx does not stall; an abort plus sync result
//   holds off the next byte while the single tx port drains the two-entry queue.
// Reset clears the frame state to hunting for sync and loads the register
//   defaults (224, 208, 255). When tx stalls, the queue fills, the input
//   register holds its byte and rx.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module escaped_frame_deframer
(
    input  logic          clk,
    input  logic          rst_n,
    efd_byte_if.sink      rx,
    efd_result_if.source  tx,
    efd_cfg_if.sink       cfg
);

    efd_pkg::efd_cfg_t          cfg_reg;
    logic                       in_valid_reg;
    logic [efd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       room;
    logic                       fire;
    efd_pkg::efd_bundle_t       bundle;

    assign fire      = in_valid_reg && room;
    assign rx.ready  = !in_valid_reg || room;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value   <= efd_pkg::SYNC_RESET;
            cfg_reg.escape_value <= efd_pkg::ESCAPE_RESET;
            cfg_reg.max_length   <= efd_pkg::MAXLEN_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                efd_pkg::REG_SYNC:   cfg_reg.sync_value   <= cfg.data;
                efd_pkg::REG_ESCAPE: cfg_reg.escape_value <= cfg.data;
                efd_pkg::REG_MAXLEN: cfg_reg.max_length   <= cfg.data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.byte_in;
        end
    end

    efd_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .byte_in (in_byte_reg),
        .cfg     (cfg_reg),
        .bundle  (bundle)
    );

    efd_outq u_outq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (fire),
        .bundle (bundle),
        .room   (room),
        .tx     (tx)
    );

endmodule
